>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file css_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants of the crane station sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package css_pkg;

   localparam int unsigned BTN_BITS  = 3;
   localparam int unsigned GRIP_BITS = 16;
   localparam int unsigned POS_BITS  = 2;
   localparam int unsigned EVT_BITS  = 2;

   localparam logic [GRIP_BITS-1:0] GRIP_TICKS_RESET = 16'd1000;

   // event codes
   localparam logic [EVT_BITS-1:0] EVT_NONE    = 2'd0;
   localparam logic [EVT_BITS-1:0] EVT_ARRIVED = 2'd1;
   localparam logic [EVT_BITS-1:0] EVT_ALREADY = 2'd2;

   // actuator outputs, latched
   typedef struct packed {
      logic grip_open;
      logic grip_close;
      logic motor_left;
      logic motor_right;
   } css_drive_type;

   // one result word, before packing
   typedef struct packed {
      logic [EVT_BITS-1:0] event_res;
      logic                busy_res;
      logic [POS_BITS-1:0] station;
      css_drive_type       drive;
   } css_result_type;

endpackage

`default_nettype wire

>>> rtl/css_seq.sv
// ----------------------------------------------------------------------------
// css_seq
// Move sequencer: phase state, gripper timer, button edge detect, drive latch.
// ----------------------------------------------------------------------------
`default_nettype none

module css_seq
   import css_pkg::*;
#(
   parameter int STATIONS = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,       // one tick accepted
   input  wire logic [BTN_BITS-1:0]  buttons_n,
   input  wire logic [BTN_BITS-1:0]  limits_n,
   input  wire logic [GRIP_BITS-1:0] grip_ticks,
   output css_result_type            res_next       // result of this tick
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CLOSE,
      PH_WAIT_RELEASE,
      PH_DRIVE,
      PH_OPEN
   } phase_type;

   phase_type            phase_ff,  phase_in;
   logic [POS_BITS-1:0]  target_ff, target_in;
   logic [POS_BITS-1:0]  pos_ff,    pos_in;
   logic [GRIP_BITS-1:0] timer_ff,  timer_in;
   logic [BTN_BITS-1:0]  prev_ff;
   logic                 moved_ff,  moved_in;
   css_drive_type        drive_ff,  drive_in;

   logic [GRIP_BITS-1:0] timer_inc;
   logic                 timer_done;
   logic                 lim_hit;
   logic [BTN_BITS-1:0]  fell;
   logic                 start;
   logic [POS_BITS-1:0]  start_target;
   logic [EVT_BITS-1:0]  event_in;

   assign timer_inc  = timer_ff + GRIP_BITS'(1);
   assign timer_done = (timer_inc >= grip_ticks) || (timer_inc == '0);
   assign fell       = prev_ff & ~buttons_n;

   // target's limit switch, active low
   always_comb begin
      case (target_ff)
         2'd1:    lim_hit = ~limits_n[0];
         2'd2:    lim_hit = ~limits_n[1];
         2'd3:    lim_hit = ~limits_n[2];
         default: lim_hit = 1'b0;
      endcase
   end

   // single falling edge with the other buttons released
   always_comb begin
      start        = 1'b0;
      start_target = '0;
      for (int i = 0; i < BTN_BITS; i++) begin
         if (i < STATIONS && fell[i] &&
             ((buttons_n | BTN_BITS'(1 << i)) == {BTN_BITS{1'b1}})) begin
            start        = 1'b1;
            start_target = POS_BITS'(i + 1);
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      target_in = target_ff;
      pos_in    = pos_ff;
      timer_in  = timer_ff;
      moved_in  = moved_ff;
      drive_in  = drive_ff;
      event_in  = EVT_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               target_in = start_target;
               phase_in  = PH_CLOSE;
               timer_in  = '0;
               drive_in  = '{grip_open: 1'b0, grip_close: 1'b1,
                             motor_left: 1'b0, motor_right: 1'b0};
            end
         end
         PH_CLOSE: begin
            timer_in = timer_inc;
            if (timer_done) begin
               if (target_ff == pos_ff) begin
                  event_in = EVT_ALREADY;
                  moved_in = 1'b0;
                  phase_in = PH_OPEN;
                  timer_in = '0;
                  drive_in = '{grip_open: 1'b1, grip_close: 1'b0,
                               motor_left: 1'b0, motor_right: 1'b0};
               end else begin
                  phase_in = PH_WAIT_RELEASE;
               end
            end
         end
         PH_WAIT_RELEASE: begin
            if (!lim_hit) begin
               drive_in.motor_right = (target_ff > pos_ff);
               drive_in.motor_left  = !(target_ff > pos_ff);
               phase_in             = PH_DRIVE;
            end
         end
         PH_DRIVE: begin
            if (lim_hit) begin
               moved_in = 1'b1;
               phase_in = PH_OPEN;
               timer_in = '0;
               drive_in = '{grip_open: 1'b1, grip_close: 1'b0,
                            motor_left: 1'b0, motor_right: 1'b0};
            end
         end
         PH_OPEN: begin
            timer_in = timer_inc;
            if (timer_done) begin
               pos_in    = target_ff;
               event_in  = moved_ff ? EVT_ARRIVED : EVT_NONE;
               target_in = '0;
               phase_in  = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      res_next.drive     = drive_in;
      res_next.station   = pos_in;
      res_next.busy_res  = (phase_in != PH_IDLE);
      res_next.event_res = event_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         target_ff <= '0;
         pos_ff    <= POS_BITS'(1);
         timer_ff  <= '0;
         prev_ff   <= '1;
         moved_ff  <= 1'b0;
         drive_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         target_ff <= target_in;
         pos_ff    <= pos_in;
         timer_ff  <= timer_in;
         prev_ff   <= buttons_n;
         moved_ff  <= moved_in;
         drive_ff  <= drive_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/crane_station_sequencer_core.sv
// ----------------------------------------------------------------------------
// crane_station_sequencer_core
// Crane carriage sequencer: station requests in, actuator and status words out.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ carries one word per timer tick: station buttons and limit switches,
//    both active low. Every accepted word yields exactly one rsp_ word.
//  - rsp_ word holds motor and gripper outputs, known station, busy flag and
//    an event code (arrived / already at target) for that tick.
//  - csr_ writes grip_ticks, the length in ticks of each gripper phase
//    (zero acts as one). Write it only while no sequence is running.
//  - Latency: the result word is valid the cycle after its tick is accepted.
//  - Throughput: one word per cycle; the sequencer state update is a single
//    pass of logic from the request word into the result register.
//  - rsp_ stall: the result register holds; req_tready stays high as long as
//    the result register is empty or is being drained in the same cycle.
//  - Reset: idle, station 1, all drives off, buttons seen as released,
//    grip_ticks 1000, result register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module crane_station_sequencer_core
   import css_pkg::*;
#(
   parameter int STATIONS = 3        // stations served, 2..3; buttons above are dead
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // tick word in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [2:0] buttons_n, [5:3] limits_n, [7:6] zero
   // result word out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [0] motor_right, [1] motor_left,
                                         // [2] grip_close, [3] grip_open,
                                         // [5:4] station, [6] busy_res,
                                         // [8:7] event_res, [15:9] zero
   // grip_ticks register
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [GRIP_BITS-1:0] grip_ticks_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   css_result_type       rsp_res_ff;
   css_result_type       res_next;
   logic                 advance;

   // accept while output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign advance    = req_tvalid && req_tready;

   css_seq #(
      .STATIONS (STATIONS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .buttons_n  (req_tdata[2:0]),
      .limits_n   (req_tdata[5:3]),
      .grip_ticks (grip_ticks_ff),
      .res_next   (res_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         grip_ticks_ff <= GRIP_TICKS_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            grip_ticks_ff <= csr_wr_data;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_res_ff <= res_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_res_ff.event_res,
                        rsp_res_ff.busy_res,
                        rsp_res_ff.station,
                        rsp_res_ff.drive.grip_open,
                        rsp_res_ff.drive.grip_close,
                        rsp_res_ff.drive.motor_left,
                        rsp_res_ff.drive.motor_right};

endmodule

`default_nettype wire

>>> rtl/css_checker.sv
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks of the crane station sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module css_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // stalled result word holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")

   // every accepted tick shows up next cycle
   `ASSERT_CLK(a_rsp_follows, clock, reset, req_tvalid && req_tready |=> rsp_tvalid, "no rsp word after accepted tick")

   // motor never driven both ways, and only during a sequence
   `ASSERT_CLK(a_motor_dir, clock, reset, rsp_tvalid && (rsp_tdata[0] || rsp_tdata[1]) |-> !(rsp_tdata[0] && rsp_tdata[1]) && rsp_tdata[6], "bad motor drive")

   // arrival ends the sequence; code 3 is unused
   `ASSERT_CLK(a_event_code, clock, reset, rsp_tvalid && rsp_tdata[8:7] != 2'd0 |-> rsp_tdata[8:7] != 2'd3 && (rsp_tdata[8:7] == 2'd2 || !rsp_tdata[6]), "bad event code")

endmodule

bind crane_station_sequencer_core css_checker u_css_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
